FILE: hdl/igniter_fire_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// igniter_fire_sequencer_unit_assert.svh
// Assertion macros shared by the igniter fire sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef IGNITER_FIRE_SEQUENCER_UNIT_ASSERT_SVH
`define IGNITER_FIRE_SEQUENCER_UNIT_ASSERT_SVH

// Condition that holds at every clock edge outside reset
`define IFS_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("ifs: invariant violated");

// Antecedent in one cycle implies consequent in the next
`define IFS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ifs: sequencing check failed");

`endif

FILE: hdl/ifs_pkg.sv
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared types and constants of the igniter fire sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ifs_pkg;

	// Widths
	localparam int LIM_W   = 6;
	localparam int POLL_W  = 8;
	localparam int TICK_W  = 11;
	localparam int PULSE_W = 3;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 11;
	localparam int PHASE_W = 2;

	// Length of each burn pulse
	localparam logic [TICK_W-1:0] BURN_PULSE_TICKS = 11'd200;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE_LIMIT  = 3'd0,
		REG_RELEASE_POLL    = 3'd1,
		REG_WARN_ON         = 3'd2,
		REG_WARN_OFF        = 3'd3,
		REG_WARN_COUNT      = 3'd4,
		REG_SETTLE          = 3'd5,
		REG_FUEL_LEAD       = 3'd6,
		REG_IGNITE          = 3'd7
	} reg_idx_t;

	// Reported phase codes
	localparam logic [PHASE_W-1:0] PHASE_IDLE       = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_QUALIFYING = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_RELEASING  = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_FIRING     = 2'd3;

	// Configuration register file
	typedef struct packed {
		logic [LIM_W-1:0]   debounce_limit;
		logic [POLL_W-1:0]  release_poll_ticks;
		logic [TICK_W-1:0]  warn_on_ticks;
		logic [TICK_W-1:0]  warn_off_ticks;
		logic [PULSE_W-1:0] warn_pulse_count;
		logic [TICK_W-1:0]  settle_ticks;
		logic [TICK_W-1:0]  fuel_lead_ticks;
		logic [TICK_W-1:0]  ignite_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		debounce_limit:     6'd32,
		release_poll_ticks: 8'd10,
		warn_on_ticks:      11'd100,
		warn_off_ticks:     11'd200,
		warn_pulse_count:   3'd3,
		settle_ticks:       11'd1000,
		fuel_lead_ticks:    11'd500,
		ignite_ticks:       11'd250
	};

	// One result item
	typedef struct packed {
		logic               jaw_open;
		logic               fuel_on;
		logic               igniter_on;
		logic [PHASE_W-1:0] phase;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/ifs_core.sv
// ----------------------------------------------------------------------------
// ifs_core
// Sequencer state and per-tick next-state logic. Advances one tick when
// step_en is high and presents the result of that tick combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module ifs_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire logic             rel,
	input  wire logic             fire,
	input  wire ifs_pkg::cfg_t    cfg,
	output ifs_pkg::result_t      result
);
	import ifs_pkg::*;

	typedef enum logic [2:0] {
		TP_IDLE, TP_QREL, TP_QFIRE, TP_REL, TP_FIRE
	} top_phase_t;

	typedef enum logic [2:0] {
		FS_READY, FS_WARN_ON, FS_WARN_OFF, FS_SETTLE,
		FS_FUEL, FS_IGNITE, FS_BURN_WAIT, FS_BURN_ON
	} fire_step_t;

	top_phase_t               top_q, top_n;
	fire_step_t               step_q, step_n;
	logic signed [LIM_W:0]    rel_int_q, rel_int_n, fire_int_q, fire_int_n;
	logic [TICK_W-1:0]        dc_q, dc_n, dc_dec;
	logic [PULSE_W-1:0]       pc_q, pc_n, pc_inc;
	logic [1:0]               prev_q;
	logic                     jaw_q, fuel_q, ign_q;
	logic                     jaw_n, fuel_n, ign_n;
	logic signed [LIM_W:0]    lim_s, rel_acc_in, rel_step, fire_step_v;
	logic                     rel_done, fire_done;
	logic [TICK_W-1:0]        poll_ticks;

	// Zero duration counts as one tick
	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		at_least_one = (v == '0) ? TICK_W'(1) : v;
	endfunction

	// Saturating up/down integrator step
	function automatic logic signed [LIM_W:0] integ(
		input logic signed [LIM_W:0] acc,
		input logic                  lvl,
		input logic signed [LIM_W:0] lim
	);
		integ = acc;
		if (!lvl && acc > -lim)
			integ = acc - 7'sd1;
		else if (lvl && acc < lim)
			integ = acc + 7'sd1;
	endfunction

	// Shared arithmetic
	assign lim_s       = (cfg.debounce_limit == '0) ? 7'sd1
	                     : signed'({1'b0, cfg.debounce_limit});
	assign rel_acc_in  = (top_q == TP_IDLE) ? '0 : rel_int_q;
	assign rel_step    = integ(rel_acc_in, rel, lim_s);
	assign fire_step_v = integ(fire_int_q, fire, lim_s);
	assign rel_done    = (rel_step >= lim_s) || (rel_step <= -lim_s);
	assign fire_done   = (fire_step_v >= lim_s) || (fire_step_v <= -lim_s);
	assign dc_dec      = dc_q - TICK_W'(1);
	assign pc_inc      = pc_q + PULSE_W'(1);
	assign poll_ticks  = at_least_one(TICK_W'(cfg.release_poll_ticks));

	// Next-state logic for one tick
	always_comb begin
		top_n      = top_q;
		step_n     = step_q;
		rel_int_n  = rel_int_q;
		fire_int_n = fire_int_q;
		dc_n       = dc_q;
		pc_n       = pc_q;
		jaw_n      = jaw_q;
		fuel_n     = fuel_q;
		ign_n      = ign_q;
		unique case (top_q)
			TP_IDLE: begin
				{jaw_n, fuel_n, ign_n} = 3'b000;
				if ({fire, rel} != prev_q) begin
					rel_int_n  = rel_step;
					fire_int_n = '0;
					top_n      = rel_done ? TP_QFIRE : TP_QREL;
				end
			end
			TP_QREL: begin
				rel_int_n = rel_step;
				if (rel_done)
					top_n = TP_QFIRE;
			end
			TP_QFIRE: begin
				fire_int_n = fire_step_v;
				if (fire_done) begin
					if (rel_int_q <= -lim_s) begin
						{jaw_n, fuel_n, ign_n} = 3'b100;
						dc_n  = poll_ticks;
						top_n = TP_REL;
					end else if (fire_step_v <= -lim_s) begin
						{jaw_n, fuel_n, ign_n} = 3'b100;
						top_n = TP_FIRE;
						pc_n  = '0;
						if (cfg.warn_pulse_count != '0) begin
							ign_n  = 1'b1;
							step_n = FS_WARN_ON;
							dc_n   = at_least_one(cfg.warn_on_ticks);
						end else begin
							step_n = FS_SETTLE;
							dc_n   = at_least_one(cfg.settle_ticks);
						end
					end else begin
						{jaw_n, fuel_n, ign_n} = 3'b000;
						top_n  = TP_IDLE;
						step_n = FS_READY;
					end
				end
			end
			TP_REL: begin
				dc_n = dc_dec;
				if (dc_dec == '0) begin
					if (rel) begin
						{jaw_n, fuel_n, ign_n} = 3'b000;
						top_n  = TP_IDLE;
						step_n = FS_READY;
					end else begin
						dc_n = poll_ticks;
					end
				end
			end
			TP_FIRE: begin
				dc_n = dc_dec;
				if (dc_dec == '0) begin
					case (step_q)
						FS_WARN_ON: begin
							ign_n  = 1'b0;
							step_n = FS_WARN_OFF;
							dc_n   = at_least_one(cfg.warn_off_ticks);
						end
						FS_WARN_OFF: begin
							pc_n = pc_inc;
							if (pc_inc < cfg.warn_pulse_count) begin
								ign_n  = 1'b1;
								step_n = FS_WARN_ON;
								dc_n   = at_least_one(cfg.warn_on_ticks);
							end else begin
								step_n = FS_SETTLE;
								dc_n   = at_least_one(cfg.settle_ticks);
							end
						end
						FS_SETTLE, FS_FUEL: begin
							if (fire) begin
								{jaw_n, fuel_n, ign_n} = 3'b000;
								top_n  = TP_IDLE;
								step_n = FS_READY;
							end else if (step_q == FS_SETTLE) begin
								fuel_n = 1'b1;
								step_n = FS_FUEL;
								dc_n   = at_least_one(cfg.fuel_lead_ticks);
							end else begin
								ign_n  = 1'b1;
								step_n = FS_IGNITE;
								dc_n   = at_least_one(cfg.ignite_ticks);
							end
						end
						FS_IGNITE, FS_BURN_ON: begin
							ign_n = 1'b0;
							if (fire) begin
								{jaw_n, fuel_n, ign_n} = 3'b000;
								top_n  = TP_IDLE;
								step_n = FS_READY;
							end else begin
								step_n = FS_BURN_WAIT;
								dc_n   = at_least_one(cfg.settle_ticks);
							end
						end
						FS_BURN_WAIT: begin
							ign_n  = 1'b1;
							step_n = FS_BURN_ON;
							dc_n   = BURN_PULSE_TICKS;
						end
						default: begin
							{jaw_n, fuel_n, ign_n} = 3'b000;
							top_n  = TP_IDLE;
							step_n = FS_READY;
						end
					endcase
				end
			end
			default: begin
				{jaw_n, fuel_n, ign_n} = 3'b000;
				top_n  = TP_IDLE;
				step_n = FS_READY;
			end
		endcase
	end

	// Result of this tick, from the next state
	always_comb begin
		result.jaw_open   = jaw_n;
		result.fuel_on    = fuel_n;
		result.igniter_on = ign_n;
		case (top_n)
			TP_IDLE: result.phase = PHASE_IDLE;
			TP_REL:  result.phase = PHASE_RELEASING;
			TP_FIRE: result.phase = PHASE_FIRING;
			default: result.phase = PHASE_QUALIFYING;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q      <= TP_IDLE;
			step_q     <= FS_READY;
			rel_int_q  <= '0;
			fire_int_q <= '0;
			dc_q       <= '0;
			pc_q       <= '0;
			prev_q     <= 2'b11;
			jaw_q      <= 1'b0;
			fuel_q     <= 1'b0;
			ign_q      <= 1'b0;
		end else if (step_en) begin
			top_q      <= top_n;
			step_q     <= step_n;
			rel_int_q  <= rel_int_n;
			fire_int_q <= fire_int_n;
			dc_q       <= dc_n;
			pc_q       <= pc_n;
			prev_q     <= {fire, rel};
			jaw_q      <= jaw_n;
			fuel_q     <= fuel_n;
			ign_q      <= ign_n;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/igniter_fire_sequencer_unit.sv
// ----------------------------------------------------------------------------
// igniter_fire_sequencer_unit: input stage register, then result register.
// One tick per cycle unless the output stalls; state updates in a single pass.
// Reset: async low; state idle, drives off, registers at their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module igniter_fire_sequencer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic [ifs_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [ifs_pkg::CFG_W-1:0]   cfg_wdata,
	// tick input
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        release_level,
	input  wire logic                        fire_level,
	// result output
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             jaw_open,
	output logic                             fuel_on,
	output logic                             igniter_on,
	output logic [ifs_pkg::PHASE_W-1:0]      phase
);
	import ifs_pkg::*;

	cfg_t    cfg_q;
	logic    s1_valid, rel_s1, fire_s1;
	logic    out_valid_q;
	result_t res_q, res_c;
	logic    advance, step_en;

	// Pipeline flow control
	assign advance  = !out_valid_q || out_ready;
	assign step_en  = s1_valid && advance;
	assign in_ready = !s1_valid || advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit     <= cfg_wdata[LIM_W-1:0];
				REG_RELEASE_POLL:   cfg_q.release_poll_ticks <= cfg_wdata[POLL_W-1:0];
				REG_WARN_ON:        cfg_q.warn_on_ticks      <= cfg_wdata[TICK_W-1:0];
				REG_WARN_OFF:       cfg_q.warn_off_ticks     <= cfg_wdata[TICK_W-1:0];
				REG_WARN_COUNT:     cfg_q.warn_pulse_count   <= cfg_wdata[PULSE_W-1:0];
				REG_SETTLE:         cfg_q.settle_ticks       <= cfg_wdata[TICK_W-1:0];
				REG_FUEL_LEAD:      cfg_q.fuel_lead_ticks    <= cfg_wdata[TICK_W-1:0];
				REG_IGNITE:         cfg_q.ignite_ticks       <= cfg_wdata[TICK_W-1:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rel_s1  <= release_level;
			fire_s1 <= fire_level;
		end
	end

	// Sequencer state and tick logic
	ifs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.rel     (rel_s1),
		.fire    (fire_s1),
		.cfg     (cfg_q),
		.result  (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en)
			res_q <= res_c;
	end

	assign out_valid  = out_valid_q;
	assign jaw_open   = res_q.jaw_open;
	assign fuel_on    = res_q.fuel_on;
	assign igniter_on = res_q.igniter_on;
	assign phase      = res_q.phase;

	// Checks
	`include "igniter_fire_sequencer_unit_assert.svh"

	`IFS_ASSERT_ALWAYS(a_fuel_needs_fire, !out_valid_q || !res_q.fuel_on || (res_q.jaw_open && res_q.phase == PHASE_FIRING))
	`IFS_ASSERT_ALWAYS(a_quiet_when_not_active, !out_valid_q || (res_q.phase != PHASE_IDLE && res_q.phase != PHASE_QUALIFYING) || (!res_q.jaw_open && !res_q.fuel_on && !res_q.igniter_on))
	`IFS_ASSERT_NEXT(a_tick_reaches_output, step_en, out_valid_q)

endmodule

`default_nettype wire

FILE: dv/igniter_fire_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// igniter_fire_sequencer_unit_tb
// Self-checking bench for the igniter fire sequencer. Button ticks go in
// through the valid/ready input. A behavioral model of the debounce, release
// and firing state machines predicts the drives and phase of every tick. The
// bench compares each result transfer with the oldest prediction. The run
// goes through directed cases, random press sequences with random idling on
// both sides, backpressure, a full burn round, and the register extremes.
// ----------------------------------------------------------------------------

module igniter_fire_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ifs_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int RX_HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES   = 8;

	// Sequencer phases and firing steps of the behavioral model
	typedef enum logic [2:0] {
		TOP_IDLE, TOP_QUAL_REL, TOP_QUAL_FIRE, TOP_RELEASING, TOP_FIRING
	} top_phase_t;

	typedef enum logic [2:0] {
		STEP_READY, STEP_WARN_ON, STEP_WARN_OFF, STEP_SETTLE,
		STEP_FUEL, STEP_IGNITE, STEP_BURN_WAIT, STEP_BURN_ON
	} fire_step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 release_level = 1'b1;
	logic                 fire_level = 1'b1;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 jaw_open;
	logic                 fuel_on;
	logic                 igniter_on;
	logic [PHASE_W-1:0]   phase;

	// Idling control
	int                   tx_idle_pct = 33;
	int                   rx_idle_pct = 54;
	logic                 rx_hold = 1'b0;

	int                   mismatches = 0;
	int                   cycle_count = 0;
	result_t              expected_drives[$];

	// Model state and its copy of the registers
	cfg_t                 cfg_live = CFG_RESET;
	top_phase_t           seq_phase = TOP_IDLE;
	fire_step_t           seq_step = STEP_READY;
	int                   rel_integ = 0;
	int                   fire_integ = 0;
	logic [TICK_W-1:0]    seq_delay = '0;
	logic [PULSE_W-1:0]   warn_pulses = '0;
	logic [1:0]           prev_levels = 2'b11;
	logic                 drv_jaw = 1'b0;
	logic                 drv_fuel = 1'b0;
	logic                 drv_ign = 1'b0;

	igniter_fire_sequencer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.release_level (release_level),
		.fire_level    (fire_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.jaw_open      (jaw_open),
		.fuel_on       (fuel_on),
		.igniter_on    (igniter_on),
		.phase         (phase)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Zero limits and durations count as one
	function automatic int nonzero(input int v);
		return (v == 0) ? 1 : v;
	endfunction

	// Saturating up/down debounce; true once the magnitude hits the limit
	function automatic bit debounce_step(inout int acc, input logic lvl, input int lim);
		if (!lvl && acc > -lim)
			acc--;
		else if (lvl && acc < lim)
			acc++;
		return (acc >= lim) || (acc <= -lim);
	endfunction

	function automatic void drop_to_idle();
		drv_jaw = 1'b0;
		drv_fuel = 1'b0;
		drv_ign = 1'b0;
		seq_phase = TOP_IDLE;
		seq_step = STEP_READY;
	endfunction

	function automatic void arm_delay(input fire_step_t s, input int ticks);
		seq_step = s;
		seq_delay = TICK_W'(nonzero(ticks));
	endfunction

	// Advance the model by one tick and return the drives it reports
	function automatic result_t sequencer_tick(input logic rel, input logic fire);
		logic [1:0] levels;
		int         lim;
		result_t    r;
		levels = {fire, rel};
		lim = nonzero(cfg_live.debounce_limit);
		case (seq_phase)
		TOP_IDLE: begin
			drv_jaw = 1'b0;
			drv_fuel = 1'b0;
			drv_ign = 1'b0;
			// any pin change starts qualification; this tick is the first release sample
			if (levels != prev_levels) begin
				rel_integ = 0;
				fire_integ = 0;
				seq_phase = TOP_QUAL_REL;
				if (debounce_step(rel_integ, rel, lim))
					seq_phase = TOP_QUAL_FIRE;
			end
		end
		TOP_QUAL_REL: begin
			if (debounce_step(rel_integ, rel, lim))
				seq_phase = TOP_QUAL_FIRE;
		end
		TOP_QUAL_FIRE: begin
			// release wins over fire; neither pressed goes back to idle
			if (debounce_step(fire_integ, fire, lim)) begin
				if (rel_integ <= -lim) begin
					drv_jaw = 1'b1;
					drv_fuel = 1'b0;
					drv_ign = 1'b0;
					seq_delay = TICK_W'(nonzero(cfg_live.release_poll_ticks));
					seq_phase = TOP_RELEASING;
				end else if (fire_integ <= -lim) begin
					drv_jaw = 1'b1;
					drv_fuel = 1'b0;
					drv_ign = 1'b0;
					seq_phase = TOP_FIRING;
					warn_pulses = '0;
					if (cfg_live.warn_pulse_count != 0) begin
						drv_ign = 1'b1;
						arm_delay(STEP_WARN_ON, cfg_live.warn_on_ticks);
					end else begin
						arm_delay(STEP_SETTLE, cfg_live.settle_ticks);
					end
				end else begin
					drop_to_idle();
				end
			end
		end
		TOP_RELEASING: begin
			// poll the release pin at each period end
			seq_delay = seq_delay - 1'b1;
			if (seq_delay == '0) begin
				if (rel)
					drop_to_idle();
				else
					seq_delay = TICK_W'(nonzero(cfg_live.release_poll_ticks));
			end
		end
		TOP_FIRING: begin
			seq_delay = seq_delay - 1'b1;
			if (seq_delay == '0) begin
				case (seq_step)
				STEP_WARN_ON: begin
					drv_ign = 1'b0;
					arm_delay(STEP_WARN_OFF, cfg_live.warn_off_ticks);
				end
				STEP_WARN_OFF: begin
					warn_pulses = warn_pulses + 1'b1;
					if (warn_pulses < cfg_live.warn_pulse_count) begin
						drv_ign = 1'b1;
						arm_delay(STEP_WARN_ON, cfg_live.warn_on_ticks);
					end else begin
						arm_delay(STEP_SETTLE, cfg_live.settle_ticks);
					end
				end
				STEP_SETTLE: begin
					if (fire) begin
						drop_to_idle();
					end else begin
						drv_fuel = 1'b1;
						arm_delay(STEP_FUEL, cfg_live.fuel_lead_ticks);
					end
				end
				STEP_FUEL: begin
					if (fire) begin
						drop_to_idle();
					end else begin
						drv_ign = 1'b1;
						arm_delay(STEP_IGNITE, cfg_live.ignite_ticks);
					end
				end
				STEP_IGNITE, STEP_BURN_ON: begin
					drv_ign = 1'b0;
					if (fire)
						drop_to_idle();
					else
						arm_delay(STEP_BURN_WAIT, cfg_live.settle_ticks);
				end
				STEP_BURN_WAIT: begin
					drv_ign = 1'b1;
					arm_delay(STEP_BURN_ON, BURN_PULSE_TICKS);
				end
				default: begin
					drop_to_idle();
				end
				endcase
			end
		end
		default: begin
			drop_to_idle();
		end
		endcase
		prev_levels = levels;

		r.jaw_open = drv_jaw;
		r.fuel_on = drv_fuel;
		r.igniter_on = drv_ign;
		case (seq_phase)
		TOP_IDLE:      r.phase = PHASE_IDLE;
		TOP_RELEASING: r.phase = PHASE_RELEASING;
		TOP_FIRING:    r.phase = PHASE_FIRING;
		default:       r.phase = PHASE_QUALIFYING;
		endcase
		return r;
	endfunction

	// Offer one tick, wait for its transfer, record the prediction
	task automatic send_tick(input logic rel, input logic fire);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		release_level <= rel;
		fire_level <= fire;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_drives.push_back(sequencer_tick(rel, fire));
	endtask

	// Stop offering until every predicted result has come out
	task automatic pause_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_drives.size() != 0)
			@(posedge clk);
	endtask

	// Write all registers with the block drained
	task automatic apply_config(input cfg_t c);
		logic [CFG_W-1:0] data;
		reg_idx_t         idx;
		pause_for_results();
		for (int i = 0; i < idx.num(); i++) begin
			idx = reg_idx_t'(i);
			case (idx)
			REG_DEBOUNCE_LIMIT: data = CFG_W'(c.debounce_limit);
			REG_RELEASE_POLL:   data = CFG_W'(c.release_poll_ticks);
			REG_WARN_ON:        data = c.warn_on_ticks;
			REG_WARN_OFF:       data = c.warn_off_ticks;
			REG_WARN_COUNT:     data = CFG_W'(c.warn_pulse_count);
			REG_SETTLE:         data = c.settle_ticks;
			REG_FUEL_LEAD:      data = c.fuel_lead_ticks;
			REG_IGNITE:         data = c.ignite_ticks;
			endcase
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= data;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_live = c;
	endtask

	// Short timings so that sequences get deep within a few dozen ticks
	function automatic cfg_t random_small_cfg();
		cfg_t c;
		c.debounce_limit = LIM_W'($urandom_range(1, 4));
		c.release_poll_ticks = POLL_W'($urandom_range(1, 6));
		c.warn_on_ticks = TICK_W'($urandom_range(1, 4));
		c.warn_off_ticks = TICK_W'($urandom_range(1, 4));
		c.warn_pulse_count = PULSE_W'($urandom_range(0, 7));
		c.settle_ticks = TICK_W'($urandom_range(1, 5));
		c.fuel_lead_ticks = TICK_W'($urandom_range(1, 4));
		c.ignite_ticks = TICK_W'($urandom_range(1, 4));
		return c;
	endfunction

	// Feed released buttons until the model is back in idle
	task automatic return_to_idle();
		do
			send_tick(1'b1, 1'b1);
		while (seq_phase != TOP_IDLE);
	endtask

	// Random button presses: mostly held presses, some bounce and noise
	task automatic press_sequences(input int count);
		int   done;
		int   len;
		int   kind;
		logic r;
		logic f;
		done = 0;
		while (done < count) begin
			kind = $urandom_range(9);
			len = (kind < 4) ? $urandom_range(1, 90) : $urandom_range(1, 40);
			for (int i = 0; i < len; i++) begin
				case (kind)
				0, 1, 2, 3: begin
					// fire held, release blips now and then
					f = 1'b0;
					r = ($urandom_range(15) != 0);
				end
				4, 5: begin
					// release held, fire at random
					r = 1'b0;
					f = 1'($urandom_range(1));
				end
				6: begin
					r = 1'b0;
					f = 1'b0;
				end
				7: begin
					r = 1'($urandom_range(1));
					f = 1'($urandom_range(1));
				end
				8: begin
					// bouncy release press
					r = ($urandom_range(3) == 0);
					f = 1'b1;
				end
				default: begin
					r = 1'b1;
					f = 1'b1;
				end
				endcase
				send_tick(r, f);
			end
			done += len;
			// let go of both buttons
			len = $urandom_range(1, 6);
			repeat (len)
				send_tick(1'b1, 1'b1);
			done += len;
			if ($urandom_range(7) == 0)
				pause_for_results();
		end
	endtask

	task automatic test_directed_cases();
		cfg_t       c;
		logic [1:0] pins_zero_cfg [15] = '{2'b11, 2'b10, 2'b10, 2'b10, 2'b10, 2'b11,
			2'b01, 2'b01, 2'b01, 2'b11, 2'b00, 2'b00, 2'b10, 2'b11, 2'b11};
		logic [1:0] pins_slow_cfg [9] = '{2'b10, 2'b10, 2'b11, 2'b10, 2'b10, 2'b10,
			2'b11, 2'b01, 2'b11};
		// all registers zero: unit limit and delays, warnings skipped
		c = '0;
		apply_config(c);
		// pins given as {release, fire}: fire run up to ignition, release hold,
		// both pressed, both released after a change
		foreach (pins_zero_cfg[i])
			send_tick(pins_zero_cfg[i][1], pins_zero_cfg[i][0]);
		// limit of two with a bounce on fire, one warning pulse, abort at settle
		c.debounce_limit = 2;
		c.warn_pulse_count = 1;
		apply_config(c);
		foreach (pins_slow_cfg[i])
			send_tick(pins_slow_cfg[i][1], pins_slow_cfg[i][0]);
	endtask

	task automatic test_random_sequences(input int tx_pct, input int rx_pct, input int count);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		apply_config(random_small_cfg());
		press_sequences(count);
	endtask

	// Receiver stalls for a long stretch while fire stays pressed
	task automatic test_backpressure();
		apply_config(random_small_cfg());
		fork
			begin
				rx_hold <= 1'b1;
				repeat (RX_HOLD_CYCLES)
					@(posedge clk);
				rx_hold <= 1'b0;
			end
			begin
				repeat (40)
					send_tick(1'b1, 1'b0);
			end
		join
		pause_for_results();
		press_sequences(10);
	endtask

	// Fire held through ignition into the second burn pulse
	task automatic test_burn_rounds();
		cfg_t c;
		c.debounce_limit = 1;
		c.release_poll_ticks = 1;
		c.warn_on_ticks = 1;
		c.warn_off_ticks = 1;
		c.warn_pulse_count = 1;
		c.settle_ticks = 1;
		c.fuel_lead_ticks = 1;
		c.ignite_ticks = 1;
		apply_config(c);
		return_to_idle();
		repeat ($urandom_range(210, 260))
			send_tick(1'b1, 1'b0);
		press_sequences(10);
	endtask

	// Largest limit, both buttons pressed: release wins after full qualification
	task automatic test_long_debounce();
		cfg_t c;
		c = random_small_cfg();
		c.debounce_limit = 63;
		c.release_poll_ticks = 1;
		c.warn_pulse_count = 7;
		apply_config(c);
		return_to_idle();
		repeat (130)
			send_tick(1'b0, 1'b0);
		repeat (4)
			send_tick(1'b1, 1'b1);
	endtask

	// Longest delays; pin changes during the first warning are ignored
	task automatic test_max_durations();
		cfg_t c;
		c.debounce_limit = 1;
		c.release_poll_ticks = 255;
		c.warn_on_ticks = 2047;
		c.warn_off_ticks = 2047;
		c.warn_pulse_count = 7;
		c.settle_ticks = 2047;
		c.fuel_lead_ticks = 2047;
		c.ignite_ticks = 2047;
		apply_config(c);
		return_to_idle();
		repeat (30)
			send_tick(1'b1, 1'b0);
		repeat (20)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// Result side: random stalls, or held off for the backpressure test
	always @(posedge clk) begin
		if (rx_hold)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	task automatic check_field(input string name, input logic [1:0] want,
			input logic [1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_drives.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual jaw %0d fuel %0d ign %0d phase %0d",
					$time, jaw_open, fuel_on, igniter_on, phase);
				mismatches++;
			end else begin
				want = expected_drives.pop_front();
				check_field("jaw_open", 2'(want.jaw_open), 2'(jaw_open));
				check_field("fuel_on", 2'(want.fuel_on), 2'(fuel_on));
				check_field("igniter_on", 2'(want.igniter_on), 2'(igniter_on));
				check_field("phase", want.phase, phase);
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_sequences(33, 54, 30);
		test_random_sequences(54, 33, 30);
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		test_backpressure();
		test_burn_rounds();
		test_long_debounce();
		test_max_durations();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_drives.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
